FILE: rtl/rc_pkg.sv
// Package for the rank compression block: sizes, widths and the compare control struct.
// No dependencies; used by rc_store, rc_rank and rank_compression.
package rc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 6;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic clear;
        logic enable;
    } cmp_ctrl_t;

endpackage

FILE: rtl/rank_compression.sv
// Rank compression top level: load sequencer, rank sweep and output register.
// Depends on rc_pkg, rc_store, rc_rank.
//
//  channel   dir  beat content
//  s_axis    in   tdata[31:0] value (signed), tlast = last
//  m_axis    out  tdata[5:0] rank, tlast = final_res, tuser = overflow
//
// Loading takes one beat per cycle. After the last beat each rank is found in steps
// (n = values held): a read of the key, a latch of the key while the first entry is read,
// a compare of each of the n values through the single read port, and a post of the result.
// Reset clears the fill count, overflow flag and sequencer; the store is not cleared.
// A stalled output holds the sweep in the post state; loading resumes after the final rank.
module rank_compression (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] rank, [7:6] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflow
);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_KEY   = 5'b00010,
        S_LATCH = 5'b00100,
        S_SWEEP = 5'b01000,
        S_POST  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [rc_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                      drop_reg, drop_next;
    logic [rc_pkg::ADDR_W-1:0] i_reg, i_next;
    logic [rc_pkg::CNT_W-1:0]  j_reg, j_next;
    logic signed [rc_pkg::VALUE_W-1:0] key_reg;

    logic                      m_valid_reg, m_valid_next;
    logic [rc_pkg::RANK_W-1:0] m_rank_reg;
    logic                      m_final_reg;
    logic                      m_ovf_reg;

    logic                      in_beat;
    logic                      room;
    logic                      slot_free;
    logic                      is_final;
    logic                      post_load;

    logic                      wr_en;
    logic                      rd_en;
    logic [rc_pkg::ADDR_W-1:0] rd_addr;
    logic signed [rc_pkg::VALUE_W-1:0] rd_data;

    rc_pkg::cmp_ctrl_t         cmp_ctrl;
    logic [rc_pkg::CNT_W-1:0]  rank_count;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign room      = (count_reg < rc_pkg::CNT_W'(rc_pkg::MAX_ITEMS));
    assign wr_en     = in_beat && room;
    assign slot_free = !m_valid_reg || m_axis_tready;
    assign is_final  = ((rc_pkg::CNT_W'(i_reg) + rc_pkg::CNT_W'(1)) == count_reg);
    assign post_load = (state_reg == S_POST) && slot_free;

    rc_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[rc_pkg::ADDR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rc_rank u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cmp_ctrl),
        .key   (key_reg),
        .data  (rd_data),
        .count (rank_count)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rd_en        = 1'b0;
        rd_addr      = i_reg;
        cmp_ctrl     = '0;
        m_valid_next = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    if (room)
                    begin
                        count_next = count_reg + rc_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        i_next     = '0;
                        state_next = S_KEY;
                    end
                end
            end
            S_KEY:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                rd_en          = 1'b1;
                rd_addr        = '0;
                j_next         = rc_pkg::CNT_W'(1);
                cmp_ctrl.clear = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmp_ctrl.enable = 1'b1;
                if (j_reg == count_reg)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg[rc_pkg::ADDR_W-1:0];
                    j_next  = j_reg + rc_pkg::CNT_W'(1);
                end
            end
            S_POST:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    if (is_final)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + rc_pkg::ADDR_W'(1);
                        state_next = S_KEY;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LATCH)
        begin
            key_reg <= rd_data;
        end
        if (post_load)
        begin
            m_rank_reg  <= rank_count[rc_pkg::RANK_W-1:0];
            m_final_reg <= is_final;
            m_ovf_reg   <= drop_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = rc_pkg::OUT_TDATA_W'(m_rank_reg);
    assign m_axis_tlast  = m_final_reg;
    assign m_axis_tuser  = m_ovf_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rc_pkg::CNT_W'(rc_pkg::MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_set_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (count_reg != '0 && rc_pkg::CNT_W'(i_reg) < count_reg))
        else $error("ranking with empty set or position past fill count");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (j_reg <= count_reg && j_reg != '0))
        else $error("sweep index out of range");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (post_load && is_final) |=> (state_reg == S_LOAD && count_reg == '0 && !drop_reg))
        else $error("set not cleared after final rank");

    a_post_slot: assert property (@(posedge clk) disable iff (!rst_n)
        post_load |=> m_axis_tvalid)
        else $error("posted rank not presented");

endmodule

FILE: rtl/rc_store.sv
// Value store: MAX_ITEMS x 32-bit synchronous memory, one write and one read port.
// Read data is registered. Depends on rc_pkg.
module rc_store (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [rc_pkg::ADDR_W-1:0]         wr_addr,
    input  logic signed [rc_pkg::VALUE_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [rc_pkg::ADDR_W-1:0]         rd_addr,
    output logic signed [rc_pkg::VALUE_W-1:0] rd_data
);

    logic signed [rc_pkg::VALUE_W-1:0] mem [rc_pkg::MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/rc_rank.sv
// Rank accumulator: counts stored values strictly below the current key, one per cycle.
// Depends on rc_pkg.
module rc_rank (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rc_pkg::cmp_ctrl_t                 ctrl,
    input  logic signed [rc_pkg::VALUE_W-1:0] key,
    input  logic signed [rc_pkg::VALUE_W-1:0] data,
    output logic [rc_pkg::CNT_W-1:0]          count
);

    logic [rc_pkg::CNT_W-1:0] count_reg;
    logic [rc_pkg::CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.enable && (data < key))
        begin
            count_next = count_reg + rc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

FILE: tb/tb_rank_compression.sv
`timescale 1ns / 100ps
// Testbench for rank_compression: streams signed value sets in and checks every rank beat
// against a scoreboard class that ranks the held values itself. Depends on rc_pkg and the RTL.
module tb_rank_compression;

    typedef struct packed {
        logic [rc_pkg::RANK_W-1:0] rank;
        logic                      final_res;
        logic                      overflow;
    } rank_beat_t;

    typedef enum {VAL_ANY, VAL_NEAR_ZERO, VAL_EXTREME} value_kind_t;

    class rank_scoreboard;
        logic signed [rc_pkg::VALUE_W-1:0] held [rc_pkg::MAX_ITEMS];
        int unsigned fill = 0;
        bit          lost = 1'b0;
        rank_beat_t  due [$];
        int          errors = 0;
        int          sets_ranked = 0;
        int          values_held = 0;
        int          values_dropped = 0;
        int          beats_checked = 0;

        task report_mismatch(string what);
            $display("ERROR @%0t: %s", $time, what);
            errors++;
        endtask

        // one accepted input beat; a last beat turns the held set into expected ranks
        function void note_value(logic signed [rc_pkg::VALUE_W-1:0] v, logic is_last);
            int unsigned below;
            rank_beat_t  b;
            if (fill < rc_pkg::MAX_ITEMS)
            begin
                held[fill] = v;
                fill++;
                values_held++;
            end
            else
            begin
                lost = 1'b1;
                values_dropped++;
            end
            if (is_last)
            begin
                for (int i = 0; i < fill; i++)
                begin
                    below = 0;
                    for (int j = 0; j < fill; j++)
                        if (held[j] < held[i])
                            below++;
                    b.rank      = below[rc_pkg::RANK_W-1:0];
                    b.final_res = (i == fill - 1);
                    b.overflow  = lost;
                    due.push_back(b);
                end
                fill = 0;
                lost = 1'b0;
                sets_ranked++;
            end
        endfunction

        task check_rank(logic [rc_pkg::OUT_TDATA_W-1:0] data, logic tlast, logic tuser);
            rank_beat_t want;
            if (due.size() == 0)
            begin
                report_mismatch($sformatf("rank beat 0x%0h with nothing pending", data));
                return;
            end
            want = due.pop_front();
            beats_checked++;
            if (data !== {{(rc_pkg::OUT_TDATA_W - rc_pkg::RANK_W){1'b0}}, want.rank})
                report_mismatch($sformatf("tdata 0x%0h, expected rank %0d", data, want.rank));
            if (tlast !== want.final_res)
                report_mismatch($sformatf("tlast %b, expected %b", tlast, want.final_res));
            if (tuser !== want.overflow)
                report_mismatch($sformatf("tuser %b, expected %b", tuser, want.overflow));
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [rc_pkg::VALUE_W-1:0]        s_axis_tdata = '0;
    logic                              s_axis_tlast = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [rc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              m_axis_tuser;

    rank_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int hold_left = 0;

    localparam logic [rc_pkg::VALUE_W-1:0] EXTREME_VALS [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

    // four short sets: extremes with ties, a single value, all equal, mixed signs
    localparam logic [rc_pkg::VALUE_W-1:0] DIR_VALS [16] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
        32'h7FFF_FFFF,
        32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5,
        32'h0000_0064, 32'hFFFF_FF9C, 32'h0000_0032};
    localparam logic [15:0] DIR_LAST = 16'h9180;

    rank_compression dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output side: check accepted beats, then pick tready (long hold-off on request)
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_rank(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (hold_req)
            begin
                hold_left = 400;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [rc_pkg::VALUE_W-1:0] pick_value();
        value_kind_t kind;
        kind = value_kind_t'($urandom_range(2));
        case (kind)
            VAL_NEAR_ZERO: return $urandom_range(8) - 4;
            VAL_EXTREME:   return EXTREME_VALS[$urandom_range(3)];
            default:       return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic [rc_pkg::VALUE_W-1:0] v, input logic is_last);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_value(v, is_last);
    endtask

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++)
            send_beat(pick_value(), k == len - 1);
    endtask

    // 64 distinct values in scrambled order, so ranks 0..63 all appear, then dropped extras
    task automatic send_full_distinct(input int extra);
        logic [rc_pkg::VALUE_W-1:0] v;
        for (int k = 0; k < rc_pkg::MAX_ITEMS + extra; k++)
        begin
            if (k < rc_pkg::MAX_ITEMS)
                v = {rc_pkg::ADDR_W'((k * 37) % rc_pkg::MAX_ITEMS),
                     (rc_pkg::VALUE_W - rc_pkg::ADDR_W)'($urandom)};
            else
                v = pick_value();
            send_beat(v, k == rc_pkg::MAX_ITEMS + extra - 1);
        end
    endtask

    task automatic run_random_sets(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
            send_set(len);
            sent += len;
        end
    endtask

    task automatic wait_for_ranks();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.due.size() != 0 && guard < 50000);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 16; k++)
            send_beat(DIR_VALS[k], DIR_LAST[k]);
        wait_for_ranks();

        // receiver held off while a full, overflowing set and more beats pile up behind it
        hold_req = 1'b1;
        send_full_distinct($urandom_range(1, 3));
        send_set(4);
        wait_for_ranks();

        idle_pct = 63;
        run_random_sets(6);
        wait_for_ranks();

        idle_pct  = 0;
        stall_pct = 63;
        hold_req  = 1'b1;
        run_random_sets(6);
        wait_for_ranks();

        idle_pct  = 32;
        stall_pct = 32;
        run_random_sets(6);
        wait_for_ranks();

        repeat (80) @(posedge clk);
        if (sb.due.size() != 0)
            sb.report_mismatch($sformatf("%0d rank beats never arrived", sb.due.size()));

        $display("Ranked %0d sets: %0d values held, %0d dropped past capacity, %0d beats checked.",
                 sb.sets_ranked, sb.values_held, sb.values_dropped, sb.beats_checked);
        $display("Covered extremes, ties, single and full sets, overflow and four pacing mixes.");
        if (sb.errors == 0)
            $display("PASS rank_compression");
        else
            $display("FAIL rank_compression");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL rank_compression");
        $finish;
    end

endmodule
